@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the supervisor rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under clock and async reset
`define ASSERT_AR(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/abs_pkg.sv @@
// ----------------------------------------------------------------------------
// abs_pkg
// types, constants and helpers of the arming and battery supervisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abs_pkg;

	localparam int ARM_W     = 16;
	localparam int MV_W      = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// elapsed counters saturate at 2^CNT_W-1, above every threshold they meet
	localparam int CNT_W = 17;
	typedef logic [CNT_W-1:0] cnt_t;
	localparam cnt_t CNT_MAX = '1;

	localparam int DISARMED_TONE_MS = 2000;
	localparam int DISARMED_LED_MS  = 1000;
	localparam int LOWBATT_LED_MS   = 500;
	localparam int CUTOFF_LED_MS    = 200;
	localparam int CUTOFF_TONE_MS   = 1000;

	localparam cnt_t DISARMED_TONE_HALF = cnt_t'(DISARMED_TONE_MS / 2);
	localparam cnt_t DISARMED_LED_HALF  = cnt_t'(DISARMED_LED_MS / 2);
	localparam cnt_t LOWBATT_LED_HALF   = cnt_t'(LOWBATT_LED_MS / 2);
	localparam cnt_t CUTOFF_LED_HALF    = cnt_t'(CUTOFF_LED_MS / 2);
	localparam cnt_t CUTOFF_TONE_HALF   = cnt_t'(CUTOFF_TONE_MS / 2);

	typedef enum logic [1:0] {
		MODE_DISARMED = 2'd0,
		MODE_NORMAL   = 2'd1,
		MODE_CUTOFF   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		TONE_NONE     = 2'd0,
		TONE_DISARMED = 2'd1,
		TONE_CUTOFF   = 2'd2
	} tone_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ARMING_ENABLED = 3'd0,
		REG_ARM_LEVEL      = 3'd1,
		REG_LOW_BATTERY_MV = 3'd2,
		REG_CUTOFF_MV      = 3'd3,
		REG_CUTOFF_TIME_MS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic             arming_enabled;
		logic [ARM_W-1:0] arm_level;
		logic [MV_W-1:0]  low_battery_mv;
		logic [MV_W-1:0]  cutoff_mv;
		logic [15:0]      cutoff_time_ms;
	} cfg_t;

	typedef struct packed {
		logic [ARM_W-1:0] arming_value;
		logic [MV_W-1:0]  cell_mv;
		logic             battery_known;
	} item_t;

	typedef struct packed {
		mode_t mode;
		logic  stop_outputs;
		logic  drive_outputs;
		logic  led_on;
		tone_t tone_request;
		logic  low_battery;
	} result_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

endpackage

@@ src/abs_in_if.sv @@
// ----------------------------------------------------------------------------
// abs_in_if
// tick channel: arming value, cell voltage, battery flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abs_in_if;
	import abs_pkg::*;

	logic             valid;
	logic             ready;
	logic [ARM_W-1:0] arming_value;
	logic [MV_W-1:0]  cell_mv;
	logic             battery_known;

	modport source (output valid, output arming_value, output cell_mv,
		output battery_known, input ready);
	modport sink (input valid, input arming_value, input cell_mv,
		input battery_known, output ready);
endinterface

@@ src/abs_out_if.sv @@
// ----------------------------------------------------------------------------
// abs_out_if
// result channel: mode, output control, led, tone, low battery
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abs_out_if;
	import abs_pkg::*;

	logic  valid;
	logic  ready;
	mode_t mode;
	logic  stop_outputs;
	logic  drive_outputs;
	logic  led_on;
	tone_t tone_request;
	logic  low_battery;

	modport source (output valid, output mode, output stop_outputs,
		output drive_outputs, output led_on, output tone_request,
		output low_battery, input ready);
	modport sink (input valid, input mode, input stop_outputs,
		input drive_outputs, input led_on, input tone_request,
		input low_battery, output ready);
endinterface

@@ src/abs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// abs_cfg_if
// register write channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abs_cfg_if;
	import abs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output reg_index, output data, input ready);
	modport sink (input valid, input reg_index, input data, output ready);
endinterface

@@ src/abs_core.sv @@
// ----------------------------------------------------------------------------
// abs_core
// supervisor state and one-tick update: mode, latch, led and elapsed counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module abs_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  abs_pkg::cfg_t    cfg,
	input  abs_pkg::item_t   itm,
	output abs_pkg::result_t res
);
	import abs_pkg::*;

	mode_t mode_q, mode_d;
	logic  lb_q, lb_d;
	logic  led_q, led_d;
	cnt_t  dis_tone_q, dis_tone_d;
	cnt_t  dis_led_q, dis_led_d;
	cnt_t  lb_led_q, lb_led_d;
	cnt_t  cut_led_q, cut_led_d;
	cnt_t  cut_tone_q, cut_tone_d;
	cnt_t  uv_q, uv_d;
	logic  stop, drive;
	tone_t tone;

	always_comb begin
		cnt_t uv_cmp;
		mode_d     = mode_q;
		lb_d       = lb_q;
		led_d      = led_q;
		dis_tone_d = sat_inc(dis_tone_q);
		dis_led_d  = sat_inc(dis_led_q);
		lb_led_d   = sat_inc(lb_led_q);
		cut_led_d  = sat_inc(cut_led_q);
		cut_tone_d = sat_inc(cut_tone_q);
		uv_cmp     = sat_inc(uv_q);
		uv_d       = uv_cmp;
		stop       = 1'b0;
		drive      = 1'b0;
		tone       = TONE_NONE;
		case (mode_q)
			MODE_DISARMED: begin
				stop = 1'b1;
				if (!cfg.arming_enabled || itm.arming_value >= cfg.arm_level) begin
					mode_d = MODE_NORMAL;
				end
				if (dis_tone_d > DISARMED_TONE_HALF) begin
					dis_tone_d = '0;
					tone       = TONE_DISARMED;
				end
				if (dis_led_d > DISARMED_LED_HALF) begin
					dis_led_d = '0;
					led_d     = !led_q;
				end
			end
			MODE_NORMAL: begin
				drive = 1'b1;
				if (cfg.arming_enabled && itm.arming_value <= cfg.arm_level) begin
					mode_d = MODE_DISARMED;
				end
				if (itm.battery_known && itm.cell_mv < cfg.low_battery_mv) begin
					lb_d = 1'b1;
				end
				if (itm.cell_mv > cfg.cutoff_mv) begin
					uv_d = '0;
				end
				// cutoff wins over disarm in the same tick
				if (uv_d > cnt_t'(cfg.cutoff_time_ms)) begin
					mode_d = MODE_CUTOFF;
				end
				if (lb_d) begin
					if (lb_led_d > LOWBATT_LED_HALF) begin
						lb_led_d = '0;
						led_d    = !led_q;
					end
				end else begin
					led_d = 1'b1;
				end
			end
			MODE_CUTOFF: begin
				if (cut_led_d > CUTOFF_LED_HALF) begin
					cut_led_d = '0;
					led_d     = !led_q;
				end
				if (cut_tone_d > CUTOFF_TONE_HALF) begin
					cut_tone_d = '0;
					tone       = TONE_CUTOFF;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_DISARMED;
			lb_q       <= 1'b0;
			led_q      <= 1'b0;
			dis_tone_q <= '0;
			dis_led_q  <= '0;
			lb_led_q   <= '0;
			cut_led_q  <= '0;
			cut_tone_q <= '0;
			uv_q       <= '0;
		end else if (step) begin
			mode_q     <= mode_d;
			lb_q       <= lb_d;
			led_q      <= led_d;
			dis_tone_q <= dis_tone_d;
			dis_led_q  <= dis_led_d;
			lb_led_q   <= lb_led_d;
			cut_led_q  <= cut_led_d;
			cut_tone_q <= cut_tone_d;
			uv_q       <= uv_d;
		end
	end

	assign res.mode          = mode_d;
	assign res.stop_outputs  = stop;
	assign res.drive_outputs = drive;
	assign res.led_on        = led_d;
	assign res.tone_request  = tone;
	assign res.low_battery   = lb_d;

	`ASSERT_NEXT(a_cutoff_terminal, clk, arst_n, mode_q == MODE_CUTOFF,
		mode_q == MODE_CUTOFF, "cutoff mode left")
	`ASSERT_NEXT(a_lowbatt_sticky, clk, arst_n, lb_q, lb_q, "low battery latch cleared")
	`ASSERT_IMPL(a_normal_led_on, clk, arst_n, step && mode_q == MODE_NORMAL && !lb_d,
		res.led_on, "led not lit in normal mode with good battery")
	`ASSERT_IMPL(a_disarmed_stops, clk, arst_n, step && mode_q == MODE_DISARMED,
		res.stop_outputs && !res.drive_outputs, "disarmed tick did not stop outputs")

endmodule

@@ src/arming_battery_supervisor_top.sv @@
// ----------------------------------------------------------------------------
// arming_battery_supervisor_top
// arming and battery supervisor advanced by one millisecond tick per beat
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  -------   ---   ------------   -----------------------------------------------
//  item      in    valid/ready    arming_value, cell_mv, battery_known
//  result    out   valid/ready    mode, stop_outputs, drive_outputs, led_on,
//                                 tone_request, low_battery
//  cfg       in    valid/ready    reg_index, data (ready is always high)
//
//  one tick beat per cycle while results are taken; a beat is registered in the input register,
//  and its result then in the output register
//  the tick update is one compare-and-increment pass over the state registers
//  asynchronous reset returns control registers to their defaults, mode disarmed, counters zero
//  a stalled result holds the output register; the input register drains into it
//  as soon as it is taken, so item ready falls only when both are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module arming_battery_supervisor_top (
	input  logic      clk,
	input  logic      arst_n,
	abs_in_if.sink    item,
	abs_out_if.source result,
	abs_cfg_if.sink   cfg
);
	import abs_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d, res_q;
	logic    out_valid_q;
	logic    advance;
	logic    step;

	// config register file, writes always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arming_enabled <= 1'b0;
			cfg_q.arm_level      <= ARM_W'(1000);
			cfg_q.low_battery_mv <= MV_W'(3500);
			cfg_q.cutoff_mv      <= MV_W'(3200);
			cfg_q.cutoff_time_ms <= 16'd1000;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.reg_index))
				REG_ARMING_ENABLED: cfg_q.arming_enabled <= cfg.data[0];
				REG_ARM_LEVEL:      cfg_q.arm_level      <= cfg.data[ARM_W-1:0];
				REG_LOW_BATTERY_MV: cfg_q.low_battery_mv <= cfg.data[MV_W-1:0];
				REG_CUTOFF_MV:      cfg_q.cutoff_mv      <= cfg.data[MV_W-1:0];
				REG_CUTOFF_TIME_MS: cfg_q.cutoff_time_ms <= cfg.data[15:0];
				default: begin
					// unused index, ignored
				end
			endcase
		end
	end

	// the input register moves on when the output register is empty or being taken
	assign advance    = !out_valid_q || result.ready;
	assign step       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.arming_value  <= item.arming_value;
			item_s1.cell_mv       <= item.cell_mv;
			item_s1.battery_known <= item.battery_known;
		end
	end

	abs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.itm    (item_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.mode          = res_q.mode;
	assign result.stop_outputs  = res_q.stop_outputs;
	assign result.drive_outputs = res_q.drive_outputs;
	assign result.led_on        = res_q.led_on;
	assign result.tone_request  = res_q.tone_request;
	assign result.low_battery   = res_q.low_battery;

	// a waiting beat in the input register always lands in the output register
	`ASSERT_NEXT(a_s1_drains, clk, arst_n, valid_s1 && advance, out_valid_q,
		"input beat lost on its way out")
	// input side only stalls when both registers are full and the result is blocked
	`ASSERT_AR(a_ready_only_full, clk, arst_n,
		item.ready || (valid_s1 && out_valid_q && !result.ready), "item stalled with room to spare")

endmodule
